FILE: rtl/core/bklb_pkg.sv
// bklb_pkg: opcodes, error codes and the scan status word shared by the
// bakery lock and barrier block; no dependencies
package bklb_pkg;

	typedef enum logic [1:0] {
		OP_ACQUIRE = 2'd0,
		OP_RELEASE = 2'd1,
		OP_ARRIVE  = 2'd2,
		OP_INVALID = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ERR_OK       = 2'd0,
		ERR_RANGE    = 2'd1,
		ERR_OVERFLOW = 2'd2,
		ERR_REQUEST  = 2'd3
	} err_t;

	typedef struct packed {
		logic done;
		logic found;
	} scan_stat_t;

endpackage

FILE: rtl/core/bklb_ram.sv
// bklb_ram: generic single write port, single read port ram with registered read
// no dependencies
module bklb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

FILE: rtl/core/bklb_scan.sv
// bklb_scan: walks the ticket ram one entry a cycle, keeping the largest
// ticket, the smallest nonzero (ticket, index) pair of the others and the
// requester's own ticket; depends on bklb_pkg
module bklb_scan #(
	parameter int MAX_REQUESTERS = 16,
	parameter int TICKET_BITS    = 16,
	parameter int CNT_W          = 5,
	parameter int XW             = 6
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [CNT_W-1:0]                  cnt,
	input  logic [XW-1:0]                     req_x,
	output logic                              rd_en,
	output logic [$clog2(MAX_REQUESTERS)-1:0] rd_addr,
	input  logic [TICKET_BITS-1:0]            rd_data,
	output logic [TICKET_BITS-1:0]            max_tk,
	output logic [TICKET_BITS-1:0]            own_tk,
	output logic [TICKET_BITS-1:0]            min_tk,
	output logic [$clog2(MAX_REQUESTERS)-1:0] min_idx,
	output bklb_pkg::scan_stat_t              stat
);
	import bklb_pkg::*;

	localparam int IDX_W = $clog2(MAX_REQUESTERS);

	logic [CNT_W-1:0]       addr_q;
	logic                   busy_q;
	logic                   v_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [TICKET_BITS-1:0] max_q;
	logic [TICKET_BITS-1:0] own_q;
	logic [TICKET_BITS-1:0] min_q;
	logic [IDX_W-1:0]       mini_q;
	logic                   found_q;
	logic [XW-1:0]          idx_x;
	logic                   is_own;

	assign rd_en   = busy_q && (addr_q != cnt);
	assign rd_addr = addr_q[IDX_W-1:0];
	assign idx_x   = {{(XW-IDX_W){1'b0}}, idx_s1};
	assign is_own  = (idx_x == req_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			busy_q  <= 1'b0;
			v_s1    <= 1'b0;
			idx_s1  <= '0;
			max_q   <= '0;
			own_q   <= '0;
			min_q   <= '0;
			mini_q  <= '0;
			found_q <= 1'b0;
		end else if (start) begin
			addr_q  <= '0;
			busy_q  <= 1'b1;
			v_s1    <= 1'b0;
			max_q   <= '0;
			own_q   <= '0;
			found_q <= 1'b0;
		end else begin
			v_s1   <= rd_en;
			idx_s1 <= rd_addr;
			if (rd_en) begin
				addr_q <= addr_q + 1'b1;
			end
			if (stat.done) begin
				busy_q <= 1'b0;
			end
			if (v_s1) begin
				if (rd_data > max_q) begin
					max_q <= rd_data;
				end
				if (is_own) begin
					own_q <= rd_data;
				end else if (rd_data != '0 && (!found_q || rd_data < min_q)) begin
					found_q <= 1'b1;
					min_q   <= rd_data;
					mini_q  <= idx_s1;
				end
			end
		end
	end

	assign stat.done  = busy_q && (addr_q == cnt) && !v_s1;
	assign stat.found = found_q;
	assign max_tk     = max_q;
	assign own_tk     = own_q;
	assign min_tk     = min_q;
	assign min_idx    = mini_q;
endmodule

FILE: rtl/core/bakery_lock_with_barrier.sv
// bakery_lock_with_barrier: top level with sequencer, ticket ram, holder and
// barrier state and the result register; depends on bklb_pkg, bklb_ram, bklb_scan
//
// A word is taken only while the block is idle. After the accept edge the scan
// reads one ticket a cycle through the single read port of the ticket ram, the
// registered read hands each ticket on to the scan, the scan then flags its end,
// and the decide state settles the request, writes the ram for an accepted
// acquire or release and loads the result register. A new word is taken once
// the previous one has been settled, even while its result is still held by a
// stalled receiver; settling the new word then waits for that result to leave.
// Ticket entries carry valid bits cleared at reset, so no clearing pass is
// needed. thread_count may only be written while no word is in flight.
module bakery_lock_with_barrier #(
	parameter int MAX_REQUESTERS = 16,
	parameter int TICKET_BITS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  thread_count,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [3:0]  requester,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        grant_valid,
	output logic [3:0]  grant_index,
	output logic [15:0] ticket_given,
	output logic        barrier_released,
	output logic        barrier_sense,
	output logic [1:0]  error_code
);
	import bklb_pkg::*;

	localparam int IDX_W = $clog2(MAX_REQUESTERS);
	localparam int CNT_W = $clog2(MAX_REQUESTERS + 1);
	localparam int XW    = ((CNT_W > 5) ? CNT_W : 5) + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE
	} state_t;

	state_t                 state_q;
	logic [4:0]             tc_q;
	op_t                    op_q;
	logic [XW-1:0]          req_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [MAX_REQUESTERS-1:0] ent_vld_q;
	logic                   ent_vld_s1;
	logic                   hold_vld_q;
	logic [IDX_W-1:0]       hold_idx_q;
	logic [MAX_REQUESTERS-1:0] arrived_q;
	logic                   sense_q;

	logic                   out_valid_q;
	logic                   grant_valid_q;
	logic [3:0]             grant_index_q;
	logic [15:0]            ticket_given_q;
	logic                   barrier_released_q;
	logic                   barrier_sense_q;
	err_t                   error_code_q;

	logic                   in_fire;
	logic [XW-1:0]          tc_x;
	logic [XW-1:0]          cnt_eff;
	logic [XW-1:0]          cnt_x;
	logic                   rd_en;
	logic [IDX_W-1:0]       rd_addr;
	logic [TICKET_BITS-1:0] ram_q;
	logic [TICKET_BITS-1:0] scan_data;
	logic [TICKET_BITS-1:0] max_tk;
	logic [TICKET_BITS-1:0] own_tk;
	logic [TICKET_BITS-1:0] min_tk;
	logic [IDX_W-1:0]       min_idx;
	scan_stat_t             stat;

	logic                   dec_fire;
	logic                   in_range;
	logic [IDX_W-1:0]       req_idx;
	logic [MAX_REQUESTERS-1:0] mask;
	logic [MAX_REQUESTERS-1:0] req_bit;
	logic [MAX_REQUESTERS-1:0] arr_set;
	err_t                   err;
	logic                   wr_en;
	logic [TICKET_BITS-1:0] wr_data;
	logic [TICKET_BITS-1:0] tk;
	logic [TICKET_BITS-1:0] own_new;
	logic                   rel;
	logic [MAX_REQUESTERS-1:0] arr_next;
	logic                   sense_next;
	logic                   cand;
	logic                   take_req;
	logic                   found_n;
	logic [IDX_W-1:0]       best;
	logic                   grant;
	logic [TICKET_BITS+15:0] tk_ext;
	logic [IDX_W+3:0]       best_ext;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign dec_fire  = (state_q == ST_DECIDE) && (!out_valid_q || !out_stall);

	// effective count: zero acts as one, capped at the requester count
	assign tc_x = {{(XW-5){1'b0}}, tc_q};
	always_comb begin
		cnt_eff = tc_x;
		if (tc_x == '0) begin
			cnt_eff = XW'(1);
		end else if (tc_x > XW'(MAX_REQUESTERS)) begin
			cnt_eff = XW'(MAX_REQUESTERS);
		end
	end

	bklb_ram #(
		.WIDTH(TICKET_BITS),
		.DEPTH(MAX_REQUESTERS)
	) u_ticket_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (req_idx),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (ram_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_s1 <= 1'b0;
		end else if (rd_en) begin
			ent_vld_s1 <= ent_vld_q[rd_addr];
		end
	end

	assign scan_data = ent_vld_s1 ? ram_q : '0;

	bklb_scan #(
		.MAX_REQUESTERS(MAX_REQUESTERS),
		.TICKET_BITS   (TICKET_BITS),
		.CNT_W         (CNT_W),
		.XW            (XW)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_fire),
		.cnt     (cnt_q),
		.req_x   (req_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (scan_data),
		.max_tk  (max_tk),
		.own_tk  (own_tk),
		.min_tk  (min_tk),
		.min_idx (min_idx),
		.stat    (stat)
	);

	// settle the request from the scan results
	assign cnt_x    = {{(XW-CNT_W){1'b0}}, cnt_q};
	assign in_range = (req_q < cnt_x);
	assign req_idx  = req_q[IDX_W-1:0];
	assign req_bit  = {{(MAX_REQUESTERS-1){1'b0}}, 1'b1} << req_idx;
	assign arr_set  = arrived_q | req_bit;

	always_comb begin
		for (int i = 0; i < MAX_REQUESTERS; i++) begin
			mask[i] = (XW'(i) < cnt_x);
		end
	end

	always_comb begin
		err        = ERR_OK;
		wr_en      = 1'b0;
		wr_data    = '0;
		tk         = '0;
		own_new    = own_tk;
		rel        = 1'b0;
		arr_next   = arrived_q;
		sense_next = sense_q;
		priority if (op_q == OP_INVALID) begin
			err = ERR_REQUEST;
		end else if (!in_range) begin
			err = ERR_RANGE;
		end else if (op_q == OP_ACQUIRE) begin
			if (own_tk != '0) begin
				err = ERR_REQUEST;
			end else if (&max_tk) begin
				err = ERR_OVERFLOW;
			end else begin
				tk      = max_tk + 1'b1;
				own_new = tk;
				wr_en   = dec_fire;
				wr_data = tk;
			end
		end else if (op_q == OP_RELEASE) begin
			if (own_tk == '0) begin
				err = ERR_REQUEST;
			end else begin
				own_new = '0;
				wr_en   = dec_fire;
			end
		end else begin
			if (arrived_q[req_idx]) begin
				err = ERR_REQUEST;
			end else if ((arr_set & mask) == mask) begin
				arr_next   = '0;
				sense_next = !sense_q;
				rel        = 1'b1;
			end else begin
				arr_next = arr_set;
			end
		end
	end

	// new holder: scan minimum over the others against the requester's own ticket
	assign cand     = in_range && (own_new != '0);
	assign take_req = cand && (!stat.found || own_new < min_tk
		|| (own_new == min_tk && req_q < {{(XW-IDX_W){1'b0}}, min_idx}));
	assign found_n  = stat.found || cand;
	assign best     = take_req ? req_idx : min_idx;
	assign grant    = found_n && (!hold_vld_q || hold_idx_q != best);
	assign tk_ext   = {16'b0, tk};
	assign best_ext = {4'b0, best};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= ST_IDLE;
			tc_q               <= 5'd16;
			op_q               <= OP_ACQUIRE;
			req_q              <= '0;
			cnt_q              <= '0;
			ent_vld_q          <= '0;
			hold_vld_q         <= 1'b0;
			hold_idx_q         <= '0;
			arrived_q          <= '0;
			sense_q            <= 1'b0;
			out_valid_q        <= 1'b0;
			grant_valid_q      <= 1'b0;
			grant_index_q      <= '0;
			ticket_given_q     <= '0;
			barrier_released_q <= 1'b0;
			barrier_sense_q    <= 1'b0;
			error_code_q       <= ERR_OK;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tc_q <= thread_count;
			end
			if (dec_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						op_q    <= op_t'(opcode);
						req_q   <= {{(XW-4){1'b0}}, requester};
						cnt_q   <= cnt_eff[CNT_W-1:0];
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (stat.done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (dec_fire) begin
						if (wr_en) begin
							ent_vld_q[req_idx] <= 1'b1;
						end
						arrived_q          <= arr_next;
						sense_q            <= sense_next;
						hold_vld_q         <= found_n;
						hold_idx_q         <= found_n ? best : '0;
						grant_valid_q      <= grant;
						grant_index_q      <= grant ? best_ext[3:0] : 4'd0;
						ticket_given_q     <= tk_ext[15:0];
						barrier_released_q <= rel;
						barrier_sense_q    <= sense_next;
						error_code_q       <= err;
						state_q            <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign grant_valid      = grant_valid_q;
	assign grant_index      = grant_index_q;
	assign ticket_given     = ticket_given_q;
	assign barrier_released = barrier_released_q;
	assign barrier_sense    = barrier_sense_q;
	assign error_code       = error_code_q;

	a_err_no_ticket: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_OK |-> ticket_given == '0)
		else $error("ticket given with an error");

	a_release_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && barrier_released |-> error_code == ERR_OK)
		else $error("barrier released by a refused arrival");

	a_holder_written: assert property (@(posedge clk) disable iff (!arst_n)
		hold_vld_q |-> ent_vld_q[hold_idx_q])
		else $error("holder entry never written");

	a_scan_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> state_q == ST_SCAN)
		else $error("scan finished outside scan state");
endmodule

FILE: sim/bakery_lock_with_barrier_tb.sv
`timescale 1ns / 1ps
// bakery_lock_with_barrier_tb: self-checking bench for the bakery lock and barrier,
// opening table and random phases over several thread counts;
// depends on bklb_pkg and bakery_lock_with_barrier
module bakery_lock_with_barrier_tb;
	import bklb_pkg::*;

	localparam int N_REQ = 16;
	localparam logic [16:0] TICKET_TOP = 17'h0FFFF;
	localparam int SETTLE_CYCLES = N_REQ + 3;
	localparam int STALL_LIMIT = 2000;
	localparam int NUM_ROWS = 25;
	localparam int SIDE_IN = 0;
	localparam int SIDE_OUT = 1;

	typedef struct packed {
		logic        grant_valid;
		logic [3:0]  grant_index;
		logic [15:0] ticket_given;
		logic        barrier_released;
		logic        barrier_sense;
		logic [1:0]  error_code;
	} lock_result_t;

	typedef struct packed {
		bit           set_count;
		logic [4:0]   count;
		op_t          op;
		logic [3:0]   req;
		bit           typed;
		lock_result_t want;
	} script_row_t;

	localparam lock_result_t NO_RESULT = '0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [4:0]  thread_count = 5'd16;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  opcode = 2'd0;
	logic [3:0]  requester = 4'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        grant_valid;
	logic [3:0]  grant_index;
	logic [15:0] ticket_given;
	logic        barrier_released;
	logic        barrier_sense;
	logic [1:0]  error_code;

	// predictor state
	logic [15:0] ticket_mem [N_REQ];
	logic        holder_on = 1'b0;
	logic [3:0]  holder_id = 4'd0;
	logic [15:0] arrived_mask = 16'd0;
	logic        sense_now = 1'b0;
	logic [4:0]  cfg_count = 5'd16;

	lock_result_t lock_results_due [$];
	script_row_t  opening_script [NUM_ROWS];
	int           fail_count = 0;
	int           calm_left [2] = '{0, 0};
	int           stall_left = 0;

	bakery_lock_with_barrier #(
		.MAX_REQUESTERS(N_REQ),
		.TICKET_BITS(16)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.thread_count(thread_count),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.requester(requester),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.grant_valid(grant_valid),
		.grant_index(grant_index),
		.ticket_given(ticket_given),
		.barrier_released(barrier_released),
		.barrier_sense(barrier_sense),
		.error_code(error_code)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int live_count(logic [4:0] c);
		if (c == 5'd0)
			return 1;
		if (c > N_REQ)
			return N_REQ;
		return int'(c);
	endfunction

	// quiet stretches keep some runs of back-to-back words
	function automatic int pick_gap(int side);
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			calm_left[side] = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, 12);
	endfunction

	function automatic lock_result_t lock_and_barrier_step(op_t op, logic [3:0] req);
		lock_result_t r;
		int cnt;
		logic [16:0] top;
		logic [15:0] full;
		logic [15:0] best_t;
		logic [3:0] best;
		bit found;
		r = '0;
		cnt = live_count(cfg_count);
		top = '0;
		best_t = '0;
		best = '0;
		found = 1'b0;
		full = (cnt == N_REQ) ? 16'hFFFF : 16'((1 << cnt) - 1);
		if (op == OP_INVALID)
			r.error_code = ERR_REQUEST;
		else if (req >= cnt)
			r.error_code = ERR_RANGE;
		else if (op == OP_ACQUIRE) begin
			if (ticket_mem[req] != 16'd0)
				r.error_code = ERR_REQUEST;
			else begin
				for (int i = 0; i < cnt; i++)
					if (ticket_mem[i] > top)
						top = {1'b0, ticket_mem[i]};
				top = top + 17'd1;
				if (top > TICKET_TOP)
					r.error_code = ERR_OVERFLOW;
				else begin
					ticket_mem[req] = top[15:0];
					r.ticket_given = top[15:0];
				end
			end
		end else if (op == OP_RELEASE) begin
			if (ticket_mem[req] == 16'd0)
				r.error_code = ERR_REQUEST;
			else
				ticket_mem[req] = 16'd0;
		end else begin
			if (arrived_mask[req])
				r.error_code = ERR_REQUEST;
			else begin
				arrived_mask[req] = 1'b1;
				if ((arrived_mask & full) == full) begin
					arrived_mask = 16'd0;
					sense_now = ~sense_now;
					r.barrier_released = 1'b1;
				end
			end
		end
		for (int i = 0; i < cnt; i++)
			if (ticket_mem[i] != 16'd0 && (!found || ticket_mem[i] < best_t)) begin
				found = 1'b1;
				best_t = ticket_mem[i];
				best = 4'(i);
			end
		if (found && (!holder_on || holder_id != best)) begin
			r.grant_valid = 1'b1;
			r.grant_index = best;
		end
		holder_on = found;
		holder_id = found ? best : 4'd0;
		r.barrier_sense = sense_now;
		return r;
	endfunction

	task automatic compare_field(string field, logic [15:0] expv, logic [15:0] actv);
		if (actv !== expv) begin
			fail_count++;
			$display("%0t: %s expected %0d got %0d", $time, field, expv, actv);
		end
	endtask

	task automatic send_word(op_t op, logic [3:0] req, bit typed, lock_result_t want);
		int gap;
		lock_result_t guess;
		gap = pick_gap(SIDE_IN);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		requester <= req;
		do @(posedge clk); while (in_stall);
		guess = lock_and_barrier_step(op, req);
		lock_results_due.push_back(typed ? want : guess);
	endtask

	// only once every word has come back
	task automatic write_count(logic [4:0] value);
		in_valid <= 1'b0;
		while (lock_results_due.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		cfg_valid <= 1'b1;
		thread_count <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_count = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(logic [4:0] count_value, int words);
		int cnt;
		int pick;
		int r;
		op_t op;
		logic [3:0] req;
		write_count(count_value);
		cnt = live_count(count_value);
		for (int n = 0; n < words; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				req = 4'($urandom_range(0, cnt - 1));
				op = (ticket_mem[req] != 16'd0) ? OP_RELEASE : OP_ACQUIRE;
			end else if (pick < 80) begin
				r = $urandom_range(0, cnt - 1);
				req = 4'(r);
				for (int k = cnt - 1; k >= 0; k--)
					if (!arrived_mask[(r + k) % cnt])
						req = 4'((r + k) % cnt);
				op = OP_ARRIVE;
			end else begin
				op = op_t'($urandom_range(0, 3));
				req = 4'($urandom_range(0, 15));
			end
			send_word(op, req, 1'b0, NO_RESULT);
		end
	endtask

	always @(posedge clk) begin : result_check
		lock_result_t want;
		int gap;
		if (out_valid && !out_stall) begin
			if (lock_results_due.size() == 0) begin
				fail_count++;
				$display("%0t: result word with nothing expected", $time);
			end else begin
				want = lock_results_due.pop_front();
				compare_field("grant_valid", 16'(want.grant_valid), 16'(grant_valid));
				compare_field("grant_index", 16'(want.grant_index), 16'(grant_index));
				compare_field("ticket_given", want.ticket_given, ticket_given);
				compare_field("barrier_released", 16'(want.barrier_released),
					16'(barrier_released));
				compare_field("barrier_sense", 16'(want.barrier_sense), 16'(barrier_sense));
				compare_field("error_code", 16'(want.error_code), 16'(error_code));
			end
			gap = pick_gap(SIDE_OUT);
			out_stall <= (gap != 0);
			stall_left = gap;
		end else if (stall_left > 0) begin
			stall_left--;
			if (stall_left == 0)
				out_stall <= 1'b0;
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		for (int i = 0; i < N_REQ; i++)
			ticket_mem[i] = 16'd0;
		opening_script = '{
			'{1'b0, 5'd0, OP_RELEASE, 4'd0, 1'b1, '{1'b0, 4'd0, 16'd0, 1'b0, 1'b0, ERR_REQUEST}},
			'{1'b0, 5'd0, OP_INVALID, 4'd15, 1'b1, '{1'b0, 4'd0, 16'd0, 1'b0, 1'b0, ERR_REQUEST}},
			'{1'b0, 5'd0, OP_ACQUIRE, 4'd15, 1'b1, '{1'b1, 4'd15, 16'd1, 1'b0, 1'b0, ERR_OK}},
			'{1'b0, 5'd0, OP_ACQUIRE, 4'd0, 1'b1, '{1'b0, 4'd0, 16'd2, 1'b0, 1'b0, ERR_OK}},
			'{1'b0, 5'd0, OP_ACQUIRE, 4'd15, 1'b1, '{1'b0, 4'd0, 16'd0, 1'b0, 1'b0, ERR_REQUEST}},
			'{1'b0, 5'd0, OP_RELEASE, 4'd15, 1'b1, '{1'b1, 4'd0, 16'd0, 1'b0, 1'b0, ERR_OK}},
			'{1'b0, 5'd0, OP_ACQUIRE, 4'd15, 1'b0, NO_RESULT},
			// zero count acts as one requester
			'{1'b1, 5'd0, OP_ACQUIRE, 4'd0, 1'b0, NO_RESULT},
			'{1'b0, 5'd0, OP_ARRIVE, 4'd0, 1'b1, '{1'b0, 4'd0, 16'd0, 1'b1, 1'b1, ERR_OK}},
			'{1'b0, 5'd0, OP_ACQUIRE, 4'd1, 1'b1, '{1'b0, 4'd0, 16'd0, 1'b0, 1'b1, ERR_RANGE}},
			// count above the maximum
			'{1'b1, 5'd31, OP_ACQUIRE, 4'd0, 1'b0, NO_RESULT},
			'{1'b0, 5'd0, OP_ARRIVE, 4'd15, 1'b0, NO_RESULT},
			'{1'b0, 5'd0, OP_ARRIVE, 4'd15, 1'b0, NO_RESULT},
			// lowered count with a stale arrival and ticket above it
			'{1'b1, 5'd3, OP_ACQUIRE, 4'd0, 1'b0, NO_RESULT},
			'{1'b0, 5'd0, OP_ARRIVE, 4'd0, 1'b0, NO_RESULT},
			'{1'b0, 5'd0, OP_ARRIVE, 4'd1, 1'b0, NO_RESULT},
			'{1'b0, 5'd0, OP_ARRIVE, 4'd2, 1'b0, NO_RESULT},
			'{1'b0, 5'd0, OP_ARRIVE, 4'd3, 1'b0, NO_RESULT},
			'{1'b0, 5'd0, OP_ACQUIRE, 4'd1, 1'b0, NO_RESULT},
			'{1'b1, 5'd16, OP_ACQUIRE, 4'd0, 1'b0, NO_RESULT},
			'{1'b0, 5'd0, OP_RELEASE, 4'd0, 1'b0, NO_RESULT},
			'{1'b0, 5'd0, OP_RELEASE, 4'd1, 1'b0, NO_RESULT},
			'{1'b0, 5'd0, OP_RELEASE, 4'd15, 1'b0, NO_RESULT},
			'{1'b0, 5'd0, OP_INVALID, 4'd0, 1'b0, NO_RESULT},
			'{1'b0, 5'd0, OP_ARRIVE, 4'd15, 1'b0, NO_RESULT}
		};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < NUM_ROWS; i++)
			if (opening_script[i].set_count)
				write_count(opening_script[i].count);
			else
				send_word(opening_script[i].op, opening_script[i].req,
					opening_script[i].typed, opening_script[i].want);

		run_phase(5'd16, 144);
		run_phase(5'd1, 144);
		run_phase(5'd0, 144);
		run_phase(5'd31, 144);
		run_phase(5'd2, 144);
		run_phase(5'($urandom_range(0, 31)), 144);
		run_phase(5'($urandom_range(3, 15)), 144);
		run_phase(5'd16, 144);

		in_valid <= 1'b0;
		while (lock_results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/bklb_pkg.sv
rtl/core/bklb_ram.sv
rtl/core/bklb_scan.sv
rtl/core/bakery_lock_with_barrier.sv
sim/bakery_lock_with_barrier_tb.sv
